// ===== rtl/mbrtu_pkg.sv =====
// Shared codes and constants for the Modbus RTU read-holding-registers master.
package mbrtu_pkg;

	// Input item codes
	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_RX_BYTE = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_TX_BYTE  = 2'd0;
	localparam logic [1:0] KIND_REGISTER = 2'd1;
	localparam logic [1:0] KIND_STATUS   = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_GOOD         = 2'd0;
	localparam logic [1:0] STATUS_INCOMPLETE   = 2'd1;
	localparam logic [1:0] STATUS_CRC_MISMATCH = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_START_REGISTER = 2'd1;
	localparam logic [1:0] CFG_REGISTER_COUNT = 2'd2;

	// Protocol constants
	localparam logic [7:0]  MODBUS_READ_HOLDING = 8'h03;
	localparam logic [15:0] CRC_INIT            = 16'hFFFF;
	localparam logic [15:0] CRC_POLY            = 16'hA001;
	localparam logic [15:0] CRC_LSB             = 16'h0001;

	// Largest count a reply can carry in this block
	localparam int unsigned REG_LIMIT = 8;

endpackage

// ===== rtl/modbus_rtu_read_registers_master.sv =====
// Modbus RTU read-holding-registers master with bit-serial CRC-16.
// Start: each of the 6 request bytes is loaded, shifted through the CRC and then output; then the 2 CRC
//   bytes follow one per cycle while the output side does not stall.
// Reply byte: the first two bytes go straight to the end check; later bytes first pass the one
//   bit-per-cycle CRC shifter; completion then emits the registers one by one. One item at a time.
// Reset (arst_n low, asynchronous): idle, config back to address 1, start 0, count 1.
module modbus_rtu_read_registers_master #(
	parameter int MAX_REGISTERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic [15:0] register_value,
	output logic [2:0]  register_index,
	output logic [1:0]  status,
	output logic        last
);
	import mbrtu_pkg::*;

	localparam int REG_CAP = (MAX_REGISTERS < REG_LIMIT) ? MAX_REGISTERS : REG_LIMIT;
	localparam int IDX_W   = (REG_CAP > 1) ? $clog2(REG_CAP) : 1;
	localparam logic [3:0] REG_CAP_N = 4'(REG_CAP);

	// Sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_REQ_LOAD = 3'd1;
	localparam logic [2:0] ST_REQ_CRC  = 3'd2;
	localparam logic [2:0] ST_REQ_OUT  = 3'd3;
	localparam logic [2:0] ST_RX_CRC   = 3'd4;
	localparam logic [2:0] ST_RX_END   = 3'd5;
	localparam logic [2:0] ST_EMIT_REG = 3'd6;
	localparam logic [2:0] ST_EMIT_ERR = 3'd7;

	// Configuration registers
	logic [7:0]  device_address_q;
	logic [15:0] start_register_q;
	logic [3:0]  register_count_q;

	// Control and transaction state
	logic [2:0]  state_q;
	logic        receiving_q;
	logic [3:0]  active_q;
	logic [4:0]  rcount_q;
	logic [15:0] crc_q;
	logic [15:0] held_q;
	logic [7:0]  pending_q;
	logic [7:0]  shift_q;
	logic [2:0]  bit_q;
	logic [2:0]  byte_q;
	logic [2:0]  emit_q;
	logic        done_q;
	logic [1:0]  err_q;

	// Register store, written once per register pair
	logic [15:0] store_q [REG_CAP];

	// Output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  tx_q;
	logic [15:0] value_q;
	logic [2:0]  index_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic        in_xfer;
	logic        out_free;
	logic [15:0] crc_next;
	logic [7:0]  req_byte;
	logic [3:0]  clamp_n;
	logic [4:0]  total;
	logic [4:0]  pos_next;
	logic [4:0]  off;
	logic        in_payload;
	logic [15:0] crc_got;
	logic        emit_last;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// One CRC bit per cycle, data taken LSB first
	always_comb begin
		crc_next = {1'b0, crc_q[15:1]};
		if (((crc_q & CRC_LSB) != 16'h0) ^ shift_q[0])
			crc_next = crc_next ^ CRC_POLY;
	end

	// Count clamp applied at start
	always_comb begin
		if (register_count_q == 4'd0)
			clamp_n = 4'd1;
		else if (register_count_q > REG_CAP_N)
			clamp_n = REG_CAP_N;
		else
			clamp_n = register_count_q;
	end

	// Request frame byte select
	always_comb begin
		unique case (byte_q)
			3'd0:    req_byte = device_address_q;
			3'd1:    req_byte = MODBUS_READ_HOLDING;
			3'd2:    req_byte = start_register_q[15:8];
			3'd3:    req_byte = start_register_q[7:0];
			3'd4:    req_byte = 8'h00;
			3'd5:    req_byte = {4'd0, active_q};
			3'd6:    req_byte = crc_q[7:0];
			default: req_byte = crc_q[15:8];
		endcase
	end

	// Reply framing: total length, payload window, CRC as received (low byte first)
	assign total      = 5'd5 + {active_q, 1'b0};
	assign pos_next   = rcount_q + 5'd1;
	assign off        = rcount_q - 5'd3;
	assign in_payload = (rcount_q >= 5'd3) && (rcount_q < total - 5'd2);
	assign crc_got    = {held_q[7:0], held_q[15:8]};
	assign emit_last  = ({1'b0, emit_q} + 4'd1) == active_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'd1;
			start_register_q <= 16'd0;
			register_count_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[7:0];
				CFG_START_REGISTER: start_register_q <= cfg_data;
				CFG_REGISTER_COUNT: register_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Register store write on the low byte of each pair
	always_ff @(posedge clk) begin
		if (in_xfer && receiving_q && func == FUNC_RX_BYTE && in_payload && off[0])
			store_q[off[IDX_W:1]] <= {pending_q, rx_byte};
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			receiving_q <= 1'b0;
			active_q    <= 4'd1;
			rcount_q    <= 5'd0;
			crc_q       <= CRC_INIT;
			held_q      <= 16'd0;
			pending_q   <= 8'd0;
			shift_q     <= 8'd0;
			bit_q       <= 3'd0;
			byte_q      <= 3'd0;
			emit_q      <= 3'd0;
			done_q      <= 1'b0;
			err_q       <= STATUS_GOOD;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_TX_BYTE;
			tx_q        <= 8'd0;
			value_q     <= 16'd0;
			index_q     <= 3'd0;
			status_q    <= STATUS_GOOD;
			last_q      <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (func == FUNC_START) begin
							active_q    <= clamp_n;
							receiving_q <= 1'b1;
							rcount_q    <= 5'd0;
							crc_q       <= CRC_INIT;
							held_q      <= 16'd0;
							pending_q   <= 8'd0;
							byte_q      <= 3'd0;
							state_q     <= ST_REQ_LOAD;
						end else if (receiving_q && func == FUNC_TIMEOUT) begin
							receiving_q <= 1'b0;
							err_q       <= STATUS_INCOMPLETE;
							state_q     <= ST_EMIT_ERR;
						end else if (receiving_q && func == FUNC_RX_BYTE) begin
							// byte older by two joins the CRC; the newest two are held back
							shift_q  <= held_q[15:8];
							bit_q    <= 3'd0;
							held_q   <= {held_q[7:0], rx_byte};
							rcount_q <= pos_next;
							done_q   <= (pos_next == total);
							if (in_payload && !off[0])
								pending_q <= rx_byte;
							state_q <= (rcount_q >= 5'd2) ? ST_RX_CRC : ST_RX_END;
						end
					end
				end

				ST_REQ_LOAD: begin
					shift_q <= req_byte;
					bit_q   <= 3'd0;
					state_q <= ST_REQ_CRC;
				end

				ST_REQ_CRC: begin
					crc_q   <= crc_next;
					shift_q <= {1'b0, shift_q[7:1]};
					bit_q   <= bit_q + 3'd1;
					if (bit_q == 3'd7)
						state_q <= ST_REQ_OUT;
				end

				ST_REQ_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_TX_BYTE;
						tx_q        <= req_byte;
						value_q     <= 16'd0;
						index_q     <= 3'd0;
						status_q    <= STATUS_GOOD;
						last_q      <= (byte_q == 3'd7);
						byte_q      <= byte_q + 3'd1;
						if (byte_q == 3'd7) begin
							crc_q   <= CRC_INIT;
							state_q <= ST_IDLE;
						end else if (byte_q < 3'd5) begin
							state_q <= ST_REQ_LOAD;
						end
					end
				end

				ST_RX_CRC: begin
					crc_q   <= crc_next;
					shift_q <= {1'b0, shift_q[7:1]};
					bit_q   <= bit_q + 3'd1;
					if (bit_q == 3'd7)
						state_q <= ST_RX_END;
				end

				ST_RX_END: begin
					if (done_q) begin
						receiving_q <= 1'b0;
						emit_q      <= 3'd0;
						if (crc_got != crc_q) begin
							err_q   <= STATUS_CRC_MISMATCH;
							state_q <= ST_EMIT_ERR;
						end else begin
							state_q <= ST_EMIT_REG;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end

				ST_EMIT_REG: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_REGISTER;
						tx_q        <= 8'd0;
						value_q     <= store_q[emit_q[IDX_W-1:0]];
						index_q     <= emit_q;
						status_q    <= STATUS_GOOD;
						last_q      <= emit_last;
						emit_q      <= emit_q + 3'd1;
						if (emit_last)
							state_q <= ST_IDLE;
					end
				end

				ST_EMIT_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_STATUS;
						tx_q        <= 8'd0;
						value_q     <= 16'd0;
						index_q     <= 3'd0;
						status_q    <= err_q;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign tx_byte        = tx_q;
	assign register_value = value_q;
	assign register_index = index_q;
	assign status         = status_q;
	assign last           = last_q;

endmodule

// ===== dv/tb_modbus_rtu_read_registers_master.sv =====
// Self-checking testbench for the Modbus RTU read-holding-registers master.
module tb_modbus_rtu_read_registers_master;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrtu_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED  = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 320;
	localparam int PHASE_ITEMS   = 40;
	localparam int SCRIPT_LEN    = 26;

	// one result transfer
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx;
		logic [15:0] value;
		logic [2:0]  index;
		logic [1:0]  status;
		logic        last;
	} master_output_t;

	// where a scripted reply byte comes from
	typedef enum logic [1:0] {BYTE_LIT, BYTE_CRC_LO, BYTE_CRC_HI, BYTE_CRC_BAD} byte_src_t;

	// scripted item; n_fixed < 0 means the predictor decides the outcome
	typedef struct {
		logic [1:0]  fn;
		logic [7:0]  data;
		byte_src_t   src;
		int          n_fixed;
		logic [1:0]  fixed_status;
		logic [63:0] fixed_frame;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_DEVICE_ADDRESS;
	logic [15:0] cfg_data = 16'h0000;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = FUNC_START;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic [15:0] register_value;
	logic [2:0]  register_index;
	logic [1:0]  status;
	logic        last;

	modbus_rtu_read_registers_master dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.tx_byte        (tx_byte),
		.register_value (register_value),
		.register_index (register_index),
		.status         (status),
		.last           (last)
	);

	// shadow configuration and master state
	logic [7:0]  cfg_address = 8'd1;
	logic [15:0] cfg_start = 16'd0;
	logic [3:0]  cfg_count = 4'd1;
	bit          rx_active = 1'b0;
	logic [4:0]  rx_count = 5'd0;
	logic [15:0] rx_crc = CRC_INIT;
	logic [15:0] tail_bytes = 16'h0000;
	logic [7:0]  high_half = 8'h00;
	logic [3:0]  held_count = 4'd1;
	logic [15:0] reg_copy [REG_LIMIT];

	master_output_t awaited_outputs [$];
	master_output_t fresh_outputs [$];
	master_output_t fixed_outputs [$];
	bit use_fixed = 1'b0;
	bit item_taken;
	bit calm = 1'b0;
	int busy_items = 0;
	int mismatches = 0;
	int cycle_count = 0;
	script_row_t script [SCRIPT_LEN];

	always #1 clk = ~clk;

	function automatic master_output_t make_output(logic [1:0] k, logic [7:0] tx,
			logic [15:0] v, logic [2:0] idx, logic [1:0] st, logic lst);
		master_output_t o;
		o.kind = k;
		o.tx = tx;
		o.value = v;
		o.index = idx;
		o.status = st;
		o.last = lst;
		return o;
	endfunction

	// CRC-16/Modbus, one byte, LSB first
	function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if ((r & CRC_LSB) != 16'h0000) r = (r >> 1) ^ CRC_POLY;
			else r = r >> 1;
		end
		return r;
	endfunction

	// advance the shadow master by one item, results go to fresh_outputs
	function automatic void compute_master_output(logic [1:0] fn, logic [7:0] data);
		logic [7:0]  frame [8];
		logic [15:0] c;
		logic [15:0] got;
		logic [3:0]  n;
		int          total;
		int          pos;
		int          off;
		item_taken = 1'b0;
		if (fn == FUNC_START) begin
			n = cfg_count;
			if (n < 4'd1) n = 4'd1;
			if (n > 4'(REG_LIMIT)) n = 4'(REG_LIMIT);
			held_count = n;
			frame[0] = cfg_address;
			frame[1] = MODBUS_READ_HOLDING;
			frame[2] = cfg_start[15:8];
			frame[3] = cfg_start[7:0];
			frame[4] = 8'h00;
			frame[5] = {4'h0, n};
			c = CRC_INIT;
			for (int i = 0; i < 6; i++) c = crc16_step(c, frame[i]);
			frame[6] = c[7:0];
			frame[7] = c[15:8];
			for (int i = 0; i < 8; i++)
				fresh_outputs.push_back(make_output(KIND_TX_BYTE, frame[i], 16'h0000, 3'd0,
					STATUS_GOOD, i == 7));
			rx_active = 1'b1;
			rx_count = 5'd0;
			rx_crc = CRC_INIT;
			tail_bytes = 16'h0000;
			high_half = 8'h00;
			item_taken = 1'b1;
		end else if (rx_active && fn == FUNC_TIMEOUT) begin
			fresh_outputs.push_back(make_output(KIND_STATUS, 8'h00, 16'h0000, 3'd0,
				STATUS_INCOMPLETE, 1'b1));
			rx_active = 1'b0;
			item_taken = 1'b1;
		end else if (rx_active && fn == FUNC_RX_BYTE) begin
			item_taken = 1'b1;
			pos = int'(rx_count);
			total = 5 + 2 * int'(held_count);
			// the last two bytes are held back from the CRC
			if (pos >= 2) rx_crc = crc16_step(rx_crc, tail_bytes[15:8]);
			tail_bytes = {tail_bytes[7:0], data};
			if (pos >= 3 && pos < total - 2) begin
				off = pos - 3;
				if (off % 2 == 0) high_half = data;
				else if (off / 2 < REG_LIMIT) reg_copy[off / 2] = {high_half, data};
			end
			rx_count = 5'(pos + 1);
			if (pos + 1 >= total) begin
				got = {tail_bytes[7:0], tail_bytes[15:8]};
				rx_active = 1'b0;
				if (got != rx_crc) begin
					fresh_outputs.push_back(make_output(KIND_STATUS, 8'h00, 16'h0000, 3'd0,
						STATUS_CRC_MISMATCH, 1'b1));
				end else begin
					for (int i = 0; i < int'(held_count); i++)
						fresh_outputs.push_back(make_output(KIND_REGISTER, 8'h00, reg_copy[i],
							3'(i), STATUS_GOOD, i + 1 == int'(held_count)));
				end
			end
		end
	endfunction

	// predict on input transfers, check output transfers (values are stable at negedge)
	always @(negedge clk) begin : scoreboard
		master_output_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				fresh_outputs.delete();
				compute_master_output(func, rx_byte);
				busy_items += int'(item_taken);
				if (use_fixed) foreach (fixed_outputs[i]) awaited_outputs.push_back(fixed_outputs[i]);
				else foreach (fresh_outputs[i]) awaited_outputs.push_back(fresh_outputs[i]);
			end
			if (out_valid === 1'b1 && out_ready) begin
				if (awaited_outputs.size() == 0) begin
					$error("result with nothing awaited: kind %0d", kind);
					mismatches++;
				end else begin
					want = awaited_outputs.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						mismatches++;
					end
					if (tx_byte !== want.tx) begin
						$error("tx_byte: expected %0h, got %0h", want.tx, tx_byte);
						mismatches++;
					end
					if (register_value !== want.value) begin
						$error("register_value: expected %0h, got %0h", want.value, register_value);
						mismatches++;
					end
					if (register_index !== want.index) begin
						$error("register_index: expected %0d, got %0d", want.index, register_index);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						mismatches++;
					end
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 38);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one input transfer, with an optional random gap in front
	task automatic send_item(input logic [1:0] fn, input logic [7:0] data);
		bit hit;
		if (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		rx_byte <= data;
		do begin
			@(negedge clk);
			hit = in_valid && in_ready;
			@(posedge clk);
		end while (!hit);
		use_fixed = 1'b0;
	endtask

	// hold the sender until every awaited result is out, then let the block settle
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (awaited_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [15:0] addr_word, input logic [15:0] start_word,
			input logic [15:0] count_word, input bit stray);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEVICE_ADDRESS;
		cfg_data <= addr_word;
		@(posedge clk);
		cfg_index <= CFG_START_REGISTER;
		cfg_data <= start_word;
		@(posedge clk);
		cfg_index <= CFG_REGISTER_COUNT;
		cfg_data <= count_word;
		@(posedge clk);
		// unmapped index must leave everything alone
		if (stray) begin
			cfg_index <= CFG_UNUSED;
			cfg_data <= 16'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_address = addr_word[7:0];
		cfg_start = start_word;
		cfg_count = count_word[3:0];
	endtask

	// one request/reply exchange, mostly well formed, sometimes broken or noise
	task automatic run_exchange();
		int          pick;
		int          mode;
		int          total;
		logic [15:0] c;
		logic [7:0]  b;
		pick = $urandom_range(99);
		if (pick < 8) begin
			case ($urandom_range(2))
				0: send_item(FUNC_TIMEOUT, 8'($urandom));
				1: send_item(FUNC_UNUSED, 8'($urandom));
				default: send_item(FUNC_RX_BYTE, 8'($urandom));
			endcase
			return;
		end
		send_item(FUNC_START, 8'($urandom));
		total = 5 + 2 * int'(held_count);
		mode = $urandom_range(99);
		if (mode >= 82 && mode < 96) begin
			// cut short: timeout, or left open for the next start to abandon
			repeat ($urandom_range(total - 1)) send_item(FUNC_RX_BYTE, 8'($urandom));
			if (mode < 90) send_item(FUNC_TIMEOUT, 8'($urandom));
		end else begin
			c = CRC_INIT;
			for (int i = 0; i < total - 2; i++) begin
				b = 8'($urandom);
				if (i < 3 && $urandom_range(3) != 0) begin
					case (i)
						0: b = cfg_address;
						1: b = MODBUS_READ_HOLDING;
						default: b = 8'(2 * int'(held_count));
					endcase
				end
				c = crc16_step(c, b);
				send_item(FUNC_RX_BYTE, b);
			end
			if (mode >= 70 && mode < 82) c = c ^ 16'($urandom_range(1, 65535));
			send_item(FUNC_RX_BYTE, c[7:0]);
			send_item(FUNC_RX_BYTE, c[15:8]);
			// trailing garbage after a complete frame
			if (mode >= 96) repeat ($urandom_range(1, 3)) send_item(FUNC_RX_BYTE, 8'($urandom));
		end
	endtask

	initial begin
		logic [15:0] frame_crc;
		logic [7:0]  data;
		int          random_base;
		int          phase_base;
		int          phase_no;
		logic [15:0] w_addr;
		logic [15:0] w_start;
		logic [15:0] w_count;

		// reset config: address 1, start 0, count 1
		script = '{
			'{FUNC_TIMEOUT, 8'h00, BYTE_LIT, 0, STATUS_GOOD, 64'h0},       // timeout when idle
			'{FUNC_RX_BYTE, 8'hFF, BYTE_LIT, 0, STATUS_GOOD, 64'h0},       // byte when idle
			'{FUNC_UNUSED, 8'h00, BYTE_LIT, 0, STATUS_GOOD, 64'h0},        // undefined function
			'{FUNC_START, 8'h00, BYTE_LIT, 8, STATUS_GOOD, 64'h010300000001840A},
			'{FUNC_TIMEOUT, 8'h00, BYTE_LIT, 1, STATUS_INCOMPLETE, 64'h0},
			'{FUNC_START, 8'hFF, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h01, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h03, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h02, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'hFF, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'hFF, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_CRC_LO, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_CRC_HI, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_LIT, 0, STATUS_GOOD, 64'h0},       // extra byte
			'{FUNC_START, 8'h00, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_CRC_LO, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'h00, BYTE_CRC_BAD, 1, STATUS_CRC_MISMATCH, 64'h0},
			'{FUNC_START, 8'h00, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_RX_BYTE, 8'hAA, BYTE_LIT, -1, STATUS_GOOD, 64'h0},
			'{FUNC_START, 8'h55, BYTE_LIT, -1, STATUS_GOOD, 64'h0},        // restart mid-reply
			'{FUNC_TIMEOUT, 8'h00, BYTE_LIT, 1, STATUS_INCOMPLETE, 64'h0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		frame_crc = CRC_INIT;
		foreach (script[r]) begin
			case (script[r].src)
				BYTE_CRC_LO: data = frame_crc[7:0];
				BYTE_CRC_HI: data = frame_crc[15:8];
				BYTE_CRC_BAD: data = frame_crc[15:8] ^ 8'h01;
				default: data = script[r].data;
			endcase
			fixed_outputs.delete();
			use_fixed = script[r].n_fixed >= 0;
			if (script[r].n_fixed == 8) begin
				for (int i = 0; i < 8; i++)
					fixed_outputs.push_back(make_output(KIND_TX_BYTE,
						script[r].fixed_frame[63 - 8 * i -: 8], 16'h0000, 3'd0, STATUS_GOOD,
						i == 7));
			end else if (script[r].n_fixed == 1) begin
				fixed_outputs.push_back(make_output(KIND_STATUS, 8'h00, 16'h0000, 3'd0,
					script[r].fixed_status, 1'b1));
			end
			send_item(script[r].fn, data);
			if (script[r].fn == FUNC_START) frame_crc = CRC_INIT;
			else if (script[r].fn == FUNC_RX_BYTE && script[r].src == BYTE_LIT)
				frame_crc = crc16_step(frame_crc, data);
		end

		// random part, in phases with a fresh configuration each
		random_base = busy_items;
		phase_no = 0;
		while (busy_items - random_base < RANDOM_ITEMS) begin
			if (rx_active) send_item(FUNC_TIMEOUT, 8'h00);
			drain_outputs();
			w_addr = 16'($urandom);
			w_start = 16'($urandom);
			w_count = 16'($urandom);
			case (phase_no)
				0: begin
					w_addr[7:0] = 8'hFF;
					w_start = 16'hFFFF;
					w_count[3:0] = 4'd8;
				end
				1: begin
					w_addr[7:0] = 8'h00;
					w_start = 16'h0000;
					w_count[3:0] = 4'd0;
				end
				2: w_count[3:0] = 4'd15;
				default: ;
			endcase
			apply_config(w_addr, w_start, w_count, phase_no == 2);
			calm = phase_no == 3;
			phase_base = busy_items;
			while (busy_items - phase_base < PHASE_ITEMS &&
					busy_items - random_base < RANDOM_ITEMS)
				run_exchange();
			phase_no++;
		end
		calm = 1'b0;

		drain_outputs();
		if (mismatches == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
